[rtl/audio_peak_minmax_pyramid_unit_macros.svh]
// Assertion macros used by the peak pyramid back end.
`ifndef AUDIO_PEAK_MINMAX_PYRAMID_UNIT_MACROS_SVH
`define AUDIO_PEAK_MINMAX_PYRAMID_UNIT_MACROS_SVH
`ifndef SYNTH
`define APMP_ASSERT(name, clk_s, rst_s, prop, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
`define APMP_NEVER(name, clk_s, rst_s, cond, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`else
`define APMP_ASSERT(name, clk_s, rst_s, prop, msg)
`define APMP_NEVER(name, clk_s, rst_s, cond, msg)
`endif
`endif

[rtl/apmp_pkg.sv]
// Types and constants of the audio peak min/max pyramid.
package apmp_pkg;
    localparam int LEVELS      = 8;
    localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LEVEL_W     = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT     = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Work for the back end: a finished level-0 bin, or a flush with the partial bin.
    typedef struct packed {
        logic    flush;
        logic    have;
        sample_t mn;
        sample_t mx;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   bin_index;
        sample_t            peak_min;
        sample_t            peak_max;
        logic               last;
    } res_t;
endpackage

[rtl/apmp_front.sv]
// Front end: config registers, sample folding into level-0 bins, flush detection.
module apmp_front
    import apmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  logic                  opcode,
    input  sample_t               sample,
    input  logic                  cmd_full,
    output logic                  cmd_push,
    output cmd_t                  cmd_data
);
    logic [3:0]       chan_cnt_reg;
    logic [16:0]      spb_reg;
    logic [CNT_W-1:0] limit_reg;

    sample_t          run_min_reg, run_min_next;
    sample_t          run_max_reg, run_max_next;
    logic [2:0]       pos_reg, pos_next;
    logic [16:0]      fib_reg, fib_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;

    logic [3:0]  chans_eff;
    logic [16:0] spb_eff;
    logic [16:0] fib_inc;
    logic        in_ok;
    logic        accept;
    logic        frame_end;
    sample_t     vmin, vmax;

    always_comb
    begin
        if (chan_cnt_reg == 4'd0)
        begin
            chans_eff = 4'd1;
        end
        else if (chan_cnt_reg > 4'd8)
        begin
            chans_eff = 4'd8;
        end
        else
        begin
            chans_eff = chan_cnt_reg;
        end

        if (spb_reg == 17'd0)
        begin
            spb_eff = 17'd1;
        end
        else if (spb_reg[16] && (spb_reg[15:0] != 16'd0))
        begin
            spb_eff = 17'h10000;
        end
        else
        begin
            spb_eff = spb_reg;
        end
    end

    assign in_ok     = push && !cmd_full;
    assign accept    = fcnt_reg < limit_reg;
    assign frame_end = ({1'b0, pos_reg} + 4'd1) >= chans_eff;
    assign fib_inc   = fib_reg + 17'd1;
    assign vmin      = (accept && (sample < run_min_reg)) ? sample : run_min_reg;
    assign vmax      = (accept && (sample > run_max_reg)) ? sample : run_max_reg;

    always_comb
    begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        pos_next     = pos_reg;
        fib_next     = fib_reg;
        fcnt_next    = fcnt_reg;
        cmd_push     = 1'b0;
        cmd_data.flush = opcode;
        cmd_data.have  = (fib_reg != 17'd0) || ((pos_reg != 3'd0) && accept);
        cmd_data.mn    = (opcode == OP_FLUSH) ? run_min_reg : vmin;
        cmd_data.mx    = (opcode == OP_FLUSH) ? run_max_reg : vmax;

        if (in_ok)
        begin
            if (opcode == OP_FLUSH)
            begin
                // hand the partial bin over and start a new stream
                cmd_push     = 1'b1;
                run_min_next = SMAX;
                run_max_next = SMIN;
                pos_next     = 3'd0;
                fib_next     = 17'd0;
                fcnt_next    = '0;
            end
            else
            begin
                run_min_next = vmin;
                run_max_next = vmax;
                if (frame_end)
                begin
                    pos_next = 3'd0;
                    if (accept)
                    begin
                        fcnt_next = fcnt_reg + 32'd1;
                        if (fib_inc >= spb_eff)
                        begin
                            cmd_push     = 1'b1;
                            run_min_next = SMAX;
                            run_max_next = SMIN;
                            fib_next     = 17'd0;
                        end
                        else
                        begin
                            fib_next = fib_inc;
                        end
                    end
                end
                else
                begin
                    // keep the interleave aligned even for dropped frames
                    pos_next = pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg <= 4'd2;
            spb_reg      <= 17'd256;
            limit_reg    <= '1;
            run_min_reg  <= SMAX;
            run_max_reg  <= SMIN;
            pos_reg      <= 3'd0;
            fib_reg      <= 17'd0;
            fcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT:   chan_cnt_reg <= cfg_data[3:0];
                    REG_SAMPLES_PER_BIN: spb_reg      <= cfg_data[16:0];
                    REG_FRAME_LIMIT:     limit_reg    <= cfg_data[CNT_W-1:0];
                    default:             ;
                endcase
            end
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
            pos_reg     <= pos_next;
            fib_reg     <= fib_next;
            fcnt_reg    <= fcnt_next;
        end
    end
endmodule

[rtl/apmp_cmdq.sv]
// Two-entry queue of bin and flush work between front and back end.
module apmp_cmdq
    import apmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);
    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rdata   = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end
endmodule

[rtl/apmp_outq.sv]
// Two-entry result queue that drives the result ports.
module apmp_outq
    import apmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t wdata,
    output logic full,
    input  logic pop,
    output res_t rdata,
    output logic empty
);
    res_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rdata   = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end
endmodule

[rtl/apmp_back.sv]
// Back end: pyramid levels, cascade walk of finished bins and flush walk.
`include "audio_peak_minmax_pyramid_unit_macros.svh"
module apmp_back
    import apmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_empty,
    output logic cmd_pop,
    output logic res_push,
    output res_t res,
    input  logic res_full
);
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BIN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    sample_t          cur_min_reg, cur_min_next;
    sample_t          cur_max_reg, cur_max_next;
    logic             have_reg, have_next;

    sample_t          pend_min_reg [LEVELS];
    sample_t          pend_max_reg [LEVELS];
    logic [LEVELS-1:0] pv_reg;
    logic [CNT_W-1:0] be_reg [LEVELS];

    logic    rd_pv;
    sample_t rd_min, rd_max;
    sample_t comb_min, comb_max;
    logic    top_lvl;
    logic    pv_store, pv_clear, clear_all;

    assign rd_pv    = pv_reg[lvl_reg];
    assign rd_min   = pend_min_reg[lvl_reg];
    assign rd_max   = pend_max_reg[lvl_reg];
    assign top_lvl  = lvl_reg == LVL_W'(LEVELS - 1);
    assign comb_min = (rd_min < cur_min_reg) ? rd_min : cur_min_reg;
    assign comb_max = (rd_max > cur_max_reg) ? rd_max : cur_max_reg;

    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        cur_min_next = cur_min_reg;
        cur_max_next = cur_max_reg;
        have_next    = have_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        pv_store     = 1'b0;
        pv_clear     = 1'b0;
        clear_all    = 1'b0;
        res.level     = LEVEL_W'(lvl_reg);
        res.bin_index = be_reg[lvl_reg];
        res.peak_min  = cur_min_reg;
        res.peak_max  = cur_max_reg;
        res.last      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop      = 1'b1;
                    lvl_next     = '0;
                    cur_min_next = cmd.mn;
                    cur_max_next = cmd.mx;
                    have_next    = cmd.have;
                    state_next   = cmd.flush ? ST_FLUSH : ST_BIN;
                end
            end
            ST_BIN:
            begin
                res.last = top_lvl || !rd_pv;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (top_lvl || !rd_pv)
                    begin
                        // below the top level, park the bin until its sibling turns up
                        pv_store   = !top_lvl;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pv_clear     = 1'b1;
                        cur_min_next = comb_min;
                        cur_max_next = comb_max;
                        lvl_next     = lvl_reg + LVL_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                res.last = top_lvl;
                if (!have_reg || !res_full)
                begin
                    res_push = have_reg;
                    if (have_reg)
                    begin
                        if (rd_pv)
                        begin
                            cur_min_next = comb_min;
                            cur_max_next = comb_max;
                        end
                    end
                    else
                    begin
                        cur_min_next = rd_min;
                        cur_max_next = rd_max;
                    end
                    have_next = have_reg || rd_pv;
                    if (top_lvl)
                    begin
                        clear_all  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lvl_reg   <= '0;
            have_reg  <= 1'b0;
            pv_reg    <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                be_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            have_reg  <= have_next;
            if (clear_all)
            begin
                pv_reg <= '0;
                for (int i = 0; i < LEVELS; i++)
                begin
                    be_reg[i] <= '0;
                end
            end
            else
            begin
                if (res_push)
                begin
                    be_reg[lvl_reg] <= be_reg[lvl_reg] + 32'd1;
                end
                if (pv_store)
                begin
                    pv_reg[lvl_reg] <= 1'b1;
                end
                if (pv_clear)
                begin
                    pv_reg[lvl_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_min_reg <= cur_min_next;
        cur_max_reg <= cur_max_next;
        if (pv_store)
        begin
            pend_min_reg[lvl_reg] <= cur_min_reg;
            pend_max_reg[lvl_reg] <= cur_max_reg;
        end
    end

    `APMP_ASSERT(a_pop_only_idle, clk, rst_n, cmd_pop |-> state_reg == ST_IDLE, "work taken mid-walk")
    `APMP_ASSERT(a_push_has_room, clk, rst_n, res_push |-> !res_full, "result pushed into full queue")
    `APMP_ASSERT(a_top_is_last, clk, rst_n, (res_push && top_lvl) |-> res.last, "top level item not last")
    `APMP_ASSERT(a_flush_clears, clk, rst_n, clear_all |=> (pv_reg == '0) && (be_reg[0] == '0), "flush left state")
    `APMP_NEVER(a_no_overwrite, clk, rst_n, pv_store && rd_pv, "waiting bin overwritten")
endmodule

[rtl/audio_peak_minmax_pyramid_unit.sv]
// Top level of the audio peak min/max pyramid.
//
// Input channel: present opcode and sample with push; an item is taken on a
// clock edge with push high and full low. Opcode sample folds one interleaved
// channel sample into the running level-0 bin; opcode flush emits the partial
// bin of every level that holds one, bottom-up, and starts a new stream.
// Result channel: while empty is low the oldest result sits on level,
// bin_index, peak_min, peak_max and last; pop takes it. last marks the final
// result caused by one input item.
// Config: cfg_we writes cfg_data to register cfg_index (0 channel_count,
// 1 samples_per_bin, 2 frame_limit); write only while idle.
// Timing: a sample is folded in the cycle it is taken; a sample that closes no
// bin can follow every cycle while full is low. A finished bin goes through the
// work queue to the back end, which takes it when idle, and its results go out
// through the result queue. The back end emits one result per cycle per level
// reached while the result queue has room; a flush walks all 8 levels.
// Reset clears all stream state and restores the register defaults.
// A stalled receiver fills the two-entry result queue, which halts the walk,
// then the two-entry work queue, which raises full.
module audio_peak_minmax_pyramid_unit
    import apmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  opcode,
    input  sample_t               sample,
    output logic                  empty,
    input  logic                  pop,
    output logic [LEVEL_W-1:0]    level,
    output logic [CNT_W-1:0]      bin_index,
    output sample_t               peak_min,
    output sample_t               peak_max,
    output logic                  last
);
    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t cmd_wdata, cmd_rdata;
    logic res_push, res_full;
    res_t res_wdata, res_rdata;

    apmp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .opcode    (opcode),
        .sample    (sample),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_wdata)
    );

    apmp_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    apmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_rdata),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_wdata),
        .res_full  (res_full)
    );

    apmp_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign full      = cmd_full;
    assign level     = res_rdata.level;
    assign bin_index = res_rdata.bin_index;
    assign peak_min  = res_rdata.peak_min;
    assign peak_max  = res_rdata.peak_max;
    assign last      = res_rdata.last;
endmodule

[test/testbench.sv]
// Self-checking testbench for the audio peak min/max pyramid unit.
module testbench
    import apmp_pkg::*;
();

    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 260;
    localparam int MAX_REPORTS    = 10;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    class peak_bin_board;
        logic [3:0]     chan_reg;
        logic [16:0]    bin_reg;
        logic [31:0]    limit_reg;

        sample_t        run_min;
        sample_t        run_max;
        int unsigned    chan_pos;
        int unsigned    frames_in_bin;
        logic [31:0]    frame_cnt;
        sample_t        pend_min [LEVELS];
        sample_t        pend_max [LEVELS];
        bit             pend_valid [LEVELS];
        logic [31:0]    emitted [LEVELS];

        res_t           due_bins [$];

        int             fails;
        int             items_seen;
        int             flushes_seen;
        int             dropped_samples;
        int             bins_checked;
        int             deepest;

        function new();
            chan_reg  = 4'd2;
            bin_reg   = 17'd256;
            limit_reg = 32'hFFFF_FFFF;
            clear_stream();
        endfunction

        function void clear_stream();
            run_min       = SMAX;
            run_max       = SMIN;
            chan_pos      = 0;
            frames_in_bin = 0;
            frame_cnt     = '0;
            for (int l = 0; l < LEVELS; l++)
            begin
                pend_min[l]   = SMAX;
                pend_max[l]   = SMIN;
                pend_valid[l] = 1'b0;
                emitted[l]    = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CHANNEL_COUNT:   chan_reg  = data[3:0];
                REG_SAMPLES_PER_BIN: bin_reg   = data[16:0];
                REG_FRAME_LIMIT:     limit_reg = data[31:0];
                default: ;
            endcase
        endfunction

        function void emit_bin(int lvl, sample_t mn, sample_t mx);
            res_t r;
            r.level     = LEVEL_W'(lvl);
            r.bin_index = emitted[lvl];
            r.peak_min  = mn;
            r.peak_max  = mx;
            r.last      = 1'b0;
            emitted[lvl] = emitted[lvl] + 32'd1;
            due_bins.insert(due_bins.size(), r);
        endfunction

        // Emit a finished level-0 bin and pair it upwards while siblings wait.
        function void cascade_bin(sample_t mn, sample_t mx);
            int lvl;
            lvl = 0;
            emit_bin(0, mn, mx);
            while (lvl < LEVELS - 1)
            begin
                if (!pend_valid[lvl])
                begin
                    pend_min[lvl]   = mn;
                    pend_max[lvl]   = mx;
                    pend_valid[lvl] = 1'b1;
                    break;
                end
                if (pend_min[lvl] < mn) mn = pend_min[lvl];
                if (pend_max[lvl] > mx) mx = pend_max[lvl];
                pend_min[lvl]   = SMAX;
                pend_max[lvl]   = SMIN;
                pend_valid[lvl] = 1'b0;
                lvl++;
                emit_bin(lvl, mn, mx);
            end
        endfunction

        function void fold_sample(sample_t s);
            int unsigned chans;
            int unsigned spb;
            bit          take;
            sample_t     mn;
            sample_t     mx;
            chans = (chan_reg == 0) ? 1 : (chan_reg > 8) ? 8 : chan_reg;
            spb   = (bin_reg == 0) ? 1 : (bin_reg > 65536) ? 65536 : bin_reg;
            take  = frame_cnt < limit_reg;
            if (take)
            begin
                if (s < run_min) run_min = s;
                if (s > run_max) run_max = s;
            end
            else
            begin
                dropped_samples++;
            end
            // The channel position advances even for dropped frames.
            if (chan_pos + 1 >= chans)
            begin
                chan_pos = 0;
                if (take)
                begin
                    frame_cnt     = frame_cnt + 32'd1;
                    frames_in_bin = frames_in_bin + 1;
                    if (frames_in_bin >= spb)
                    begin
                        mn            = run_min;
                        mx            = run_max;
                        run_min       = SMAX;
                        run_max       = SMIN;
                        frames_in_bin = 0;
                        cascade_bin(mn, mx);
                    end
                end
            end
            else
            begin
                chan_pos++;
            end
        endfunction

        // Emit the partial bin of every level that holds one, bottom-up, then start afresh.
        function void flush_pyramid();
            bit      have;
            bit      p;
            sample_t cmin;
            sample_t cmax;
            sample_t mn;
            sample_t mx;
            have = frames_in_bin > 0 || (chan_pos > 0 && frame_cnt < limit_reg);
            cmin = run_min;
            cmax = run_max;
            if (have) emit_bin(0, cmin, cmax);
            for (int l = 1; l < LEVELS; l++)
            begin
                p  = pend_valid[l-1];
                mn = SMAX;
                mx = SMIN;
                if (p)
                begin
                    mn = pend_min[l-1];
                    mx = pend_max[l-1];
                end
                if (have)
                begin
                    if (cmin < mn) mn = cmin;
                    if (cmax > mx) mx = cmax;
                end
                if (p || have)
                begin
                    emit_bin(l, mn, mx);
                    cmin = mn;
                    cmax = mx;
                    have = 1'b1;
                end
                else
                begin
                    have = 1'b0;
                end
            end
            clear_stream();
        endfunction

        function void note_item(logic op, sample_t s);
            int before_cnt;
            before_cnt = due_bins.size();
            items_seen++;
            if (op == OP_FLUSH)
            begin
                flushes_seen++;
                flush_pyramid();
            end
            else
            begin
                fold_sample(s);
            end
            if (due_bins.size() > before_cnt)
                due_bins[due_bins.size() - 1].last = 1'b1;
        endfunction

        function void complain(string msg);
            fails++;
            if (fails <= MAX_REPORTS)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [LEVEL_W-1:0] lv, logic [CNT_W-1:0] idx,
                                   sample_t mn, sample_t mx, logic lst);
            res_t want;
            if (due_bins.size() == 0)
            begin
                complain($sformatf("unexpected bin: level %0d index %0d min %0d max %0d last %0b",
                                   lv, idx, mn, mx, lst));
                return;
            end
            want = due_bins[0];
            due_bins.delete(0);
            bins_checked++;
            if (lv > deepest) deepest = lv;
            if (lv !== want.level || idx !== want.bin_index || mn !== want.peak_min ||
                mx !== want.peak_max || lst !== want.last)
                complain($sformatf({"bin mismatch: expected level %0d index %0d min %0d ",
                                    "max %0d last %0b, got level %0d index %0d min %0d ",
                                    "max %0d last %0b"},
                                   want.level, want.bin_index, want.peak_min, want.peak_max,
                                   want.last, lv, idx, mn, mx, lst));
        endfunction

        function int pending();
            return due_bins.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    logic                   full;
    logic                   opcode;
    sample_t                sample;
    logic                   empty;
    logic                   pop;
    logic [LEVEL_W-1:0]     level;
    logic [CNT_W-1:0]       bin_index;
    sample_t                peak_min;
    sample_t                peak_max;
    logic                   last;

    peak_bin_board          sb;
    bit                     tx_burst;
    bit                     rx_burst;
    bit                     hold_req;

    audio_peak_minmax_pyramid_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .level     (level),
        .bin_index (bin_index),
        .peak_min  (peak_min),
        .peak_max  (peak_max),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(level, bin_index, peak_min, peak_max, last);
            if (push && !full)
                sb.note_item(opcode, sample);
        end
    end

    function automatic sample_t draw_sample();
        case ($urandom_range(15, 0))
            0:       return SMAX;
            1:       return SMIN;
            2:       return '0;
            3:       return '1;
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic send_item(logic op, sample_t s);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(10, 0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        opcode <= op;
        sample <= s;
        do @(posedge clk); while (full);
    endtask

    // Hold the input until every expected bin has been taken.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(int unsigned ch, int unsigned spb, logic [31:0] lim);
        int                    i;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        for (i = 0; i < 4; i++)
        begin
            idx  = CFG_IDX_W'(i);
            data = $urandom();
            case (idx)
                REG_CHANNEL_COUNT:   data[3:0]  = ch[3:0];
                REG_SAMPLES_PER_BIN: data[16:0] = spb[16:0];
                REG_FRAME_LIMIT:     data       = lim;
                REG_SPARE:           ;
                default: ;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            sb.write_reg(idx, data);
        end
        cfg_we <= 1'b0;
    endtask

    // Receiver: random pop gaps, plus one long hold to back the block up.
    initial
    begin
        int gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = rx_burst ? 0 : $urandom_range(10, 0);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d bins outstanding",
                 quiet, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned ch;
        int unsigned spb;
        logic [31:0] lim;
        int          n;
        int          pause_at;
        int          p;
        int          i;

        sb        = new();
        push      = 1'b0;
        opcode    = OP_SAMPLE;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_CHANNEL_COUNT;
        cfg_data  = '0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;
        hold_req  = 1'b0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: flush on an empty pyramid, then a partial frame.
        send_item(OP_FLUSH, sample_t'($urandom()));
        send_item(OP_SAMPLE, SMAX);
        send_item(OP_SAMPLE, SMIN);
        send_item(OP_SAMPLE, '0);
        send_item(OP_SAMPLE, '1);
        send_item(OP_SAMPLE, sample_t'(1));
        send_item(OP_FLUSH, '0);
        settle();

        // One sample per bin: each sample closes a bin and cascades.
        set_config(1, 1, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, SMIN);
        send_item(OP_SAMPLE, SMAX);
        send_item(OP_SAMPLE, sample_t'(24'h555555));
        send_item(OP_SAMPLE, sample_t'(24'hAAAAAA));
        send_item(OP_FLUSH, '0);
        settle();

        // Zero channel count and bin size act as one; only the first frame counts.
        set_config(0, 0, 1);
        repeat (5) send_item(OP_SAMPLE, draw_sample());
        send_item(OP_FLUSH, draw_sample());
        send_item(OP_FLUSH, draw_sample());
        settle();

        // Channel count above range acts as eight; limit of zero drops everything.
        set_config(15, 2, 0);
        repeat (3) send_item(OP_SAMPLE, draw_sample());
        send_item(OP_FLUSH, draw_sample());
        settle();

        p = 0;
        while (sb.items_seen < TARGET_ITEMS)
        begin
            n        = $urandom_range(45, 20);
            ch       = ($urandom_range(5, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(4, 1);
            pause_at = -1;
            case ($urandom_range(9, 0))
                0:       spb = 0;
                1:       spb = 8;
                default: spb = $urandom_range(4, 1);
            endcase
            case ($urandom_range(7, 0))
                0, 1:    lim = $urandom_range(30, 0);
                2:       lim = $urandom();
                default: lim = 32'hFFFF_FFFF;
            endcase
            tx_burst = ($urandom_range(3, 0) == 0);
            rx_burst = ($urandom_range(3, 0) == 0);
            case (p)
                1:
                begin
                    // Long single-sample run: fills the block while the receiver
                    // holds off, and cascades right to the top level.
                    ch       = 1;
                    spb      = 1;
                    lim      = 32'hFFFF_FFFF;
                    n        = 130;
                    tx_burst = 1'b1;
                    rx_burst = 1'b0;
                    hold_req = 1'b1;
                end
                3:
                begin
                    ch  = 8;
                    spb = 65536;
                    lim = 32'hFFFF_FFFF;
                    n   = 12;
                end
                4:       pause_at = n / 2;
                5:
                begin
                    ch  = 1;
                    spb = 17'h1FFFF;
                    n   = 5;
                end
                default: ;
            endcase
            set_config(ch, spb, lim);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(29, 0) == 0)
                    send_item(OP_FLUSH, draw_sample());
                else
                    send_item(OP_SAMPLE, draw_sample());
                if (i == pause_at)
                    drain_results();
            end
            send_item(OP_FLUSH, draw_sample());
            settle();
            p++;
        end

        $display("Covered %0d items (%0d flushes, %0d dropped samples) over %0d settings.",
                 sb.items_seen, sb.flushes_seen, sb.dropped_samples, p + 4);
        $display("Checked %0d bins up to level %0d, %0d errors.",
                 sb.bins_checked, sb.deepest, sb.fails);
        if (sb.fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
